// ===== hdl/lbbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lbbp_pkg: shared types and constants for the LRU block buffer pool
// Request codes, stream field widths, result word layout and the
// controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lbbp_pkg;

  // Request codes (carried in s_axis_tuser)
  localparam logic [1:0] REQ_ACCESS = 2'd0;
  localparam logic [1:0] REQ_DIRTY  = 2'd1;
  localparam logic [1:0] REQ_ERROR  = 2'd2;

  // Stream field widths
  localparam int REQ_W   = 2;
  localparam int BLKF_W  = 24;
  localparam int IDXF_W  = 3;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 32;

  // Input word layout
  localparam int IN_BLK_LSB = 0;
  localparam int IN_IDX_LSB = 24;

  // Result word layout, lowest bit first
  localparam int OUT_HIT     = 0;
  localparam int OUT_SLOT    = 1;
  localparam int OUT_WB      = 4;
  localparam int OUT_WBB     = 5;
  localparam int OUT_WBZ     = 29;
  localparam int OUT_FETCH   = 30;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming request
    logic lookup;  // tag compare and victim pick
    logic commit;  // update pool state, load result register
  } lbbp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a word this cycle
  } lbbp_status_t;

endpackage

// ===== hdl/lbbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbbp_ctrl: request sequencer
// Steps each request through lookup and commit; overlaps the next accept
// with a commit that can retire.
// ----------------------------------------------------------------------------
module lbbp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lbbp_pkg::lbbp_status_t status_i,
  output lbbp_pkg::lbbp_cmd_t   cmd_o
);
  import lbbp_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOK   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       retire;
  logic       take;

  // Commit retires once the result register is free
  assign retire     = (state_q == ST_COMMIT) && status_i.out_free;
  assign in_ready_o = (state_q == ST_IDLE) || retire;
  assign take       = in_valid_i && in_ready_o;

  assign cmd_o.load   = take;
  assign cmd_o.lookup = (state_q == ST_LOOK);
  assign cmd_o.commit = retire;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (take)        state_d = ST_LOOK;
        else if (retire) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/lbbp_dp.sv =====
// ----------------------------------------------------------------------------
// lbbp_dp: buffer pool datapath
// Slot tags, valid/dirty/error flags, per-slot recency rank, parallel tag
// compare, victim pick and the result register.
// ----------------------------------------------------------------------------
module lbbp_dp #(
  parameter int POOL_SLOTS = 8,
  parameter int BLOCK_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lbbp_pkg::lbbp_cmd_t         cmd_i,
  output lbbp_pkg::lbbp_status_t      status_o,
  input  logic [lbbp_pkg::REQ_W-1:0]  req_type_i,
  input  logic [lbbp_pkg::BLKF_W-1:0] block_number_i,
  input  logic [lbbp_pkg::IDXF_W-1:0] slot_index_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [lbbp_pkg::OUT_W-1:0]  out_data_o
);
  import lbbp_pkg::*;

  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_RANK = SW'(POOL_SLOTS - 1);

  // Captured request
  logic [REQ_W-1:0]      req_q;
  logic [BLOCK_BITS-1:0] blk_q;
  logic [IDXF_W-1:0]     idx_q;

  // Pool state
  logic [BLOCK_BITS-1:0] tag_q [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] valid_q, dirty_q, err_q;
  logic [SW-1:0]         rank_q [POOL_SLOTS];

  // Lookup results
  logic                  hit_q;
  logic [SW-1:0]         sel_q;
  logic [SW-1:0]         sel_rank_q;
  logic                  wb_q, wbz_q;
  logic [BLOCK_BITS-1:0] wbb_q;

  // Result register
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_data_q;

  // Lookup logic
  logic [POOL_SLOTS-1:0] match, victim;
  logic [SW-1:0]         hit_slot, hit_rank, vic_slot;
  logic                  any_hit;
  logic                  is_access;
  logic [SW-1:0]         idx_sel;
  logic                  mark_ok;
  logic [31:0]           slot32, wbb32;
  logic [OUT_W-1:0]      res_word;

  assign is_access = (req_q == REQ_ACCESS);

  // Parallel tag compare and LRU victim (rank at the tail)
  always_comb begin
    hit_slot = '0;
    hit_rank = '0;
    vic_slot = '0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      match[i]  = valid_q[i] && (tag_q[i] == blk_q);
      victim[i] = (rank_q[i] == LAST_RANK);
      if (match[i]) begin
        hit_slot = hit_slot | SW'(i);
        hit_rank = hit_rank | rank_q[i];
      end
      if (victim[i]) vic_slot = vic_slot | SW'(i);
    end
    any_hit = |match;
  end

  // Mark requests: slot must exist and hold a block
  assign idx_sel = SW'(idx_q);
  assign mark_ok = (int'(idx_q) < POOL_SLOTS) && valid_q[idx_sel];

  // Result word
  assign slot32 = 32'(sel_q);
  assign wbb32  = 32'(wbb_q);
  always_comb begin
    res_word = '0;
    if (is_access) begin
      res_word[OUT_HIT]                 = hit_q;
      res_word[OUT_SLOT +: 3]           = slot32[2:0];
      res_word[OUT_WB]                  = wb_q;
      res_word[OUT_WBB +: BLKF_W]       = wbb32[BLKF_W-1:0];
      res_word[OUT_WBZ]                 = wbz_q;
      res_word[OUT_FETCH]               = !hit_q;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      blk_q <= BLOCK_BITS'(block_number_i);
      idx_q <= slot_index_i;
    end
  end

  // Lookup stage registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q      <= any_hit;
      sel_q      <= any_hit ? hit_slot : vic_slot;
      sel_rank_q <= any_hit ? hit_rank : LAST_RANK;
      wb_q       <= !any_hit && valid_q[vic_slot] && dirty_q[vic_slot];
      wbb_q      <= (!any_hit && valid_q[vic_slot] && dirty_q[vic_slot]) ?
                    tag_q[vic_slot] : '0;
      wbz_q      <= !any_hit && valid_q[vic_slot] && dirty_q[vic_slot] &&
                    err_q[vic_slot];
    end
  end

  // Tag store, written on a miss
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && is_access && !hit_q) tag_q[sel_q] <= blk_q;
  end

  // Flags and recency ranks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      err_q   <= '0;
      for (int i = 0; i < POOL_SLOTS; i++) rank_q[i] <= SW'(i);
    end else if (cmd_i.commit) begin
      if (is_access) begin
        // Move selected slot to front, age those ahead of it
        for (int i = 0; i < POOL_SLOTS; i++) begin
          if (SW'(i) == sel_q)              rank_q[i] <= '0;
          else if (rank_q[i] < sel_rank_q)  rank_q[i] <= rank_q[i] + 1'b1;
        end
        if (!hit_q) begin
          valid_q[sel_q] <= 1'b1;
          dirty_q[sel_q] <= 1'b0;
          err_q[sel_q]   <= 1'b0;
        end
      end else if (req_q == REQ_DIRTY && mark_ok) begin
        dirty_q[idx_sel] <= 1'b1;
      end else if (req_q == REQ_ERROR && mark_ok) begin
        err_q[idx_sel] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_data_q <= res_word;
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

// ===== hdl/lru_block_buffer_pool.sv =====
// ----------------------------------------------------------------------------
// lru_block_buffer_pool: most-recently-used ordered block buffer pool
// Streams requests in, returns one result word per request.
// ----------------------------------------------------------------------------
// Each request word returns exactly one result word. A request passes through
// a lookup step, the parallel tag compare and victim pick (registered), and
// a commit step that updates the recency ranks and slot flags and loads the result
// register. The next request is accepted in the commit cycle, so a new request
// overlaps the previous commit while the result side keeps up; a full
// result register holds the commit until it drains. Recency is kept as a
// rank per slot (0 = most recent); after reset slot i has rank i, so the
// first miss takes the highest slot. No clearing pass is needed.
module lru_block_buffer_pool #(
  parameter int POOL_SLOTS = 8,
  parameter int BLOCK_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [lbbp_pkg::IN_W-1:0]   s_axis_tdata,  // block_number[23:0], slot_index[26:24]
  input  logic [lbbp_pkg::REQ_W-1:0]  s_axis_tuser,  // req_type[1:0]
  // Result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [lbbp_pkg::OUT_W-1:0]  m_axis_tdata   // hit[0], slot[3:1], writeback[4],
                                                     // writeback_block[28:5],
                                                     // writeback_zeroed[29], fetch[30]
);
  import lbbp_pkg::*;

  lbbp_cmd_t    cmd;
  lbbp_status_t status;

  lbbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lbbp_dp #(
    .POOL_SLOTS (POOL_SLOTS),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .req_type_i     (s_axis_tuser),
    .block_number_i (s_axis_tdata[IN_BLK_LSB +: BLKF_W]),
    .slot_index_i   (s_axis_tdata[IN_IDX_LSB +: IDXF_W]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_data_o     (m_axis_tdata)
  );

`ifndef NO_ASSERTIONS
  // A hit never asks for a fetch or a write-back
  a_hit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OUT_HIT] |->
      !m_axis_tdata[OUT_FETCH] && !m_axis_tdata[OUT_WB])
    else $error("hit result carries fetch or write-back");

  // Write-back only on a miss that fetches; zeroed flag only with write-back
  a_wb_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[OUT_WB] || m_axis_tdata[OUT_WBZ]) |->
      m_axis_tdata[OUT_WB] && m_axis_tdata[OUT_FETCH])
    else $error("inconsistent write-back flags");

  // An accepted request occupies the lookup cycle
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted during lookup");
`endif

endmodule
